>>> src/slot_allocator_with_sweep_unit_assert.svh
// Assertion macros for the slot allocator.
// Used by the top level; no other dependencies.
`ifndef SLOT_ALLOCATOR_WITH_SWEEP_UNIT_ASSERT_SVH
`define SLOT_ALLOCATOR_WITH_SWEEP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SASW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SASW_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define SASW_ASSERT(lbl, clk, rst_n, prop, msg)
`define SASW_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

>>> src/sasw_pkg.sv
// Shared types and constants of the slot allocator.
// No dependencies.
`default_nettype none
package sasw_pkg;
    localparam int SLOTS_DEF     = 256;
    localparam int MAX_GRANT_DEF = 64;

    localparam logic [1:0] MODE_RESERVE = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_PUBLISH = 2'd2;
    localparam logic [1:0] MODE_MARK    = 2'd3;

    typedef struct packed {
        logic used;
        logic pub;
        logic rec;
    } t_slot_bits;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic op_wr;
        logic sweep_init;
        logic sweep_step;
        logic prep;
        logic pop_bit;
        logic pop_chk;
        logic scan_rd;
        logic scan_chk;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_reserve;
        logic need_sweep;
        logic sweep_last;
        logic pop_any;
        logic scan_done;
    } t_sts;
endpackage
`default_nettype wire

>>> src/sasw_ram.sv
// Generic RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module sasw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> src/sasw_ctrl.sv
// Controller state machine of the slot allocator.
// Depends on sasw_pkg.
`default_nettype none
module sasw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire sasw_pkg::t_sts i_sts,
    output sasw_pkg::t_cmd     o_cmd,
    output logic               o_busy
);
    import sasw_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_OP, S_CHECK, S_SWEEP, S_SWTAIL, S_PREP,
        S_POP_RD, S_POP_BIT, S_POP_CHK, S_SCAN_RD, S_SCAN_CHK, S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.is_reserve ? S_CHECK : S_OP;
                end
            end
            S_OP: begin
                o_cmd.op_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_CHECK: begin
                if (i_sts.need_sweep) begin
                    o_cmd.sweep_init = 1'b1;
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) n_state = S_SWTAIL;
            end
            S_SWTAIL: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_POP_RD;
            end
            S_POP_RD: begin
                n_state = i_sts.pop_any ? S_POP_BIT : S_SCAN_RD;
            end
            S_POP_BIT: begin
                o_cmd.pop_bit = 1'b1;
                n_state = S_POP_CHK;
            end
            S_POP_CHK: begin
                o_cmd.pop_chk = 1'b1;
                n_state = S_POP_RD;
            end
            S_SCAN_RD: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                o_cmd.scan_chk = 1'b1;
                n_state = S_SCAN_RD;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

>>> src/sasw_dp.sv
// Datapath of the slot allocator: slot bit RAM, recycle stack RAM, counters, result register.
// Depends on sasw_pkg and sasw_ram.
`default_nettype none
module sasw_dp #(
    parameter int SLOTS     = sasw_pkg::SLOTS_DEF,
    parameter int MAX_GRANT = sasw_pkg::MAX_GRANT_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sasw_pkg::t_cmd i_cmd,
    output sasw_pkg::t_sts      o_sts,
    input  wire logic           i_cfg_we,
    input  wire logic [7:0]     i_cfg_data,
    input  wire logic [1:0]     i_mode,
    input  wire logic [6:0]     i_request_count,
    input  wire logic [7:0]     i_slot_index,
    output logic                o_strobe,
    output logic [16:0]         o_row_position,
    output logic                o_granted,
    output logic                o_contiguous,
    output logic                o_last
);
    import sasw_pkg::*;

    localparam int IW  = $clog2(SLOTS);
    localparam int MXV = (SLOTS > MAX_GRANT) ? SLOTS : MAX_GRANT;
    localparam int CW  = $clog2(MXV + 1);
    localparam int BW  = $bits(t_slot_bits);

    logic [7:0]       r_block;
    logic [CW-1:0]    r_cnt, r_free, r_need, r_len, r_ptop, r_pidx, r_steps;
    logic [IW-1:0]    r_sweep_i, r_sw_a, r_ptr, r_slot;
    logic [1:0]       r_mode;
    logic             r_slot_ok, r_sw_v;
    logic             r_contig;
    logic             r_pend;
    logic [16:0]      r_pend_row;

    logic [IW-1:0]    s_idx, stk_rdata, g_idx, bit_raddr, bit_waddr;
    logic [BW-1:0]    bit_rdata;
    t_slot_bits       bit_rd, bit_wd, op_bits;
    logic             s_ok, g_en, sw_hit, bit_we;
    logic [CW-1:0]    n_need, n_take;
    logic [16:0]      g_row;

    assign s_idx  = IW'(i_slot_index);
    assign s_ok   = (32'(i_slot_index) < 32'(SLOTS));
    assign bit_rd = t_slot_bits'(bit_rdata);
    assign sw_hit = bit_rd.used & bit_rd.pub & bit_rd.rec;
    assign n_need = (r_cnt < r_free) ? r_cnt : r_free;
    assign n_take = (n_need < r_len) ? n_need : r_len;

    sasw_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_stack (
        .i_clk  (i_clk),
        .i_we   (r_sw_v && sw_hit),
        .i_waddr(r_len[IW-1:0]),
        .i_wdata(r_sw_a),
        .i_raddr(r_pidx[IW-1:0]),
        .o_rdata(stk_rdata)
    );

    sasw_ram #(.WIDTH(BW), .DEPTH(SLOTS)) u_bits (
        .i_clk  (i_clk),
        .i_we   (bit_we),
        .i_waddr(bit_waddr),
        .i_wdata(bit_wd),
        .i_raddr(bit_raddr),
        .o_rdata(bit_rdata)
    );

    always_comb begin
        bit_raddr = s_idx;
        if (i_cmd.sweep_step) begin
            bit_raddr = r_sweep_i;
        end else if (i_cmd.pop_bit) begin
            bit_raddr = stk_rdata;
        end else if (i_cmd.scan_rd) begin
            bit_raddr = r_ptr;
        end
    end

    always_comb begin
        op_bits = bit_rd;
        case (r_mode)
            MODE_FREE: begin
                op_bits.used = 1'b0;
            end
            MODE_PUBLISH: begin
                if (bit_rd.used) op_bits.pub = 1'b1;
            end
            MODE_MARK: begin
                op_bits.rec = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        g_en  = 1'b0;
        g_idx = r_ptr;
        if (i_cmd.pop_chk) begin
            g_idx = stk_rdata;
            g_en  = (32'(stk_rdata) < 32'(SLOTS)) && !bit_rd.used;
        end else if (i_cmd.scan_chk) begin
            g_en  = !bit_rd.used;
        end
    end

    always_comb begin
        bit_we    = 1'b0;
        bit_waddr = r_sweep_i;
        bit_wd    = '0;
        if (i_cmd.clear_step) begin
            bit_we = 1'b1;
        end else if (i_cmd.op_wr) begin
            bit_we    = r_slot_ok;
            bit_waddr = r_slot;
            bit_wd    = op_bits;
        end else if (r_sw_v) begin
            bit_we     = sw_hit;
            bit_waddr  = r_sw_a;
            bit_wd.pub = bit_rd.pub;
        end else if (g_en) begin
            bit_we      = 1'b1;
            bit_waddr   = g_idx;
            bit_wd.used = 1'b1;
        end
    end

    assign g_row = 17'(32'(g_idx) + 32'd1 + 32'(r_block) * 32'(SLOTS));

    assign o_sts.is_reserve = (i_mode == MODE_RESERVE);
    assign o_sts.need_sweep = (r_cnt > r_free);
    assign o_sts.sweep_last = (r_sweep_i == IW'(SLOTS - 1));
    assign o_sts.pop_any    = (r_pidx != r_ptop);
    assign o_sts.scan_done  = (r_need == '0) || (r_steps == CW'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block   <= '0;
            r_free    <= CW'(SLOTS);
            r_len     <= '0;
            r_ptr     <= '0;
            r_sweep_i <= '0;
            r_sw_v    <= 1'b0;
            r_pend    <= 1'b0;
            o_strobe  <= 1'b0;
        end else begin
            r_sw_v   <= i_cmd.sweep_step;
            r_sw_a   <= r_sweep_i;
            o_strobe <= (g_en && r_pend) || i_cmd.finish;
            if (i_cfg_we) r_block <= i_cfg_data;
            if (i_cmd.accept) begin
                r_cnt     <= (32'(i_request_count) > 32'(MAX_GRANT)) ?
                             CW'(MAX_GRANT) : CW'(i_request_count);
                r_contig  <= 1'b1;
                r_pend    <= 1'b0;
                r_mode    <= i_mode;
                r_slot    <= s_idx;
                r_slot_ok <= s_ok;
            end
            if (i_cmd.op_wr && r_slot_ok && r_mode == MODE_FREE && bit_rd.used) begin
                r_free <= r_free + CW'(1);
            end
            if (i_cmd.clear_step || i_cmd.sweep_step) begin
                r_sweep_i <= r_sweep_i + IW'(1);
            end
            if (i_cmd.sweep_init) begin
                r_sweep_i <= '0;
                r_len     <= '0;
                r_contig  <= (r_cnt > CW'(1)) ? 1'b0 : 1'b1;
            end
            if (r_sw_v && sw_hit) begin
                r_free <= r_free + CW'(1);
                r_len  <= r_len + CW'(1);
            end
            if (i_cmd.prep) begin
                r_need  <= n_need;
                r_ptop  <= r_len;
                r_pidx  <= r_len - n_take;
                r_len   <= r_len - n_take;
                r_steps <= '0;
            end
            if (i_cmd.pop_chk) r_pidx <= r_pidx + CW'(1);
            if (i_cmd.scan_chk) begin
                r_ptr   <= (r_ptr == IW'(SLOTS - 1)) ? '0 : r_ptr + IW'(1);
                r_steps <= r_steps + CW'(1);
            end
            if (g_en) begin
                r_free     <= r_free - CW'(1);
                r_need     <= r_need - CW'(1);
                r_pend     <= 1'b1;
                r_pend_row <= g_row;
                if (r_pend) begin
                    o_row_position <= r_pend_row;
                    o_granted      <= 1'b1;
                    o_contiguous   <= r_contig;
                    o_last         <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                o_row_position <= r_pend ? r_pend_row : '0;
                o_granted      <= r_pend;
                o_contiguous   <= r_contig;
                o_last         <= 1'b1;
                r_pend         <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> src/slot_allocator_with_sweep_unit.sv
// After reset busy stays high while the slot bitmaps are cleared (sync active low).
// Free, publish and mark keep busy high only in the single write state S_OP.
// A reserve keeps busy high through the check, the sweep when one runs, the stack pops
// and the slot scan; the next transaction may start once busy drops.
// Each grant leaves the cycle after the next grant is found, the final result in the
// first cycle with busy low; the receiver cannot stall. Stack contents undefined until written.
`default_nettype none
`include "slot_allocator_with_sweep_unit_assert.svh"
module slot_allocator_with_sweep_unit #(
    parameter int SLOTS     = sasw_pkg::SLOTS_DEF,
    parameter int MAX_GRANT = sasw_pkg::MAX_GRANT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic [1:0]  i_mode,
    input  wire logic [6:0]  i_request_count,
    input  wire logic [7:0]  i_slot_index,
    output logic             o_strobe,
    output logic [16:0]      o_row_position,
    output logic             o_granted,
    output logic             o_contiguous,
    output logic             o_last
);
    import sasw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sasw_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    sasw_dp #(.SLOTS(SLOTS), .MAX_GRANT(MAX_GRANT)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_request_count(i_request_count),
        .i_slot_index   (i_slot_index),
        .o_strobe       (o_strobe),
        .o_row_position (o_row_position),
        .o_granted      (o_granted),
        .o_contiguous   (o_contiguous),
        .o_last         (o_last)
    );

    `SASW_ASSERT(a_strobe_from_work, i_clk, i_rst_n, o_strobe |-> $past(busy), "stray result")
    `SASW_ASSERT(a_last_idle, i_clk, i_rst_n, (o_strobe && o_last) |-> !busy, "last while busy")
    `SASW_ASSERT(a_nogrant_last, i_clk, i_rst_n, (o_strobe && !o_granted) |-> o_last, "bad no-grant")
    `SASW_ASSERT_NEXT(a_mode_oneshot, i_clk, i_rst_n, (start && !busy && i_mode != MODE_RESERVE), busy ##1 !busy, "slot op stalled")
endmodule
`default_nettype wire

>>> test/slot_allocator_with_sweep_unit_tb.sv
// Self-checking testbench for slot_allocator_with_sweep_unit.
// Drives reserve, free, publish and mark transactions and checks every grant
// against an in-bench allocator model. Depends on sasw_pkg and the unit itself.
`timescale 1ns / 1ps

module slot_allocator_with_sweep_unit_tb;
    import sasw_pkg::*;

    localparam int NSLOT     = 256;
    localparam int GRANT_CAP = 64;
    localparam int CYCLE_CAP = 2000000;

    typedef struct packed {
        logic [16:0] row;
        logic        granted;
        logic        contig;
        logic        last;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic [1:0]  i_mode = MODE_RESERVE;
    logic [6:0]  i_request_count = 7'd0;
    logic [7:0]  i_slot_index = 8'd0;
    logic        o_strobe;
    logic [16:0] o_row_position;
    logic        o_granted;
    logic        o_contiguous;
    logic        o_last;

    slot_allocator_with_sweep_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_request_count(i_request_count),
        .i_slot_index   (i_slot_index),
        .o_strobe       (o_strobe),
        .o_row_position (o_row_position),
        .o_granted      (o_granted),
        .o_contiguous   (o_contiguous),
        .o_last         (o_last)
    );

    always #2 i_clk = ~i_clk;

    // allocator state mirror
    bit          used_map [NSLOT];
    bit          pub_map  [NSLOT];
    bit          recl_map [NSLOT];
    logic [7:0]  recycle  [NSLOT];
    int          recycle_len;
    int          free_slots;
    int          scan_pos;
    logic [7:0]  block_idx;

    t_grant      grant_q[$];
    t_grant      got;
    t_grant      want;
    int          errors = 0;
    int          cycles = 0;

    task automatic report_mismatch(input string what);
        errors++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    function automatic t_grant make_grant(input int idx, input bit contig);
        t_grant g;
        g.row     = 17'(idx + 1 + int'(block_idx) * NSLOT);
        g.granted = 1'b1;
        g.contig  = contig;
        g.last    = 1'b0;
        return g;
    endfunction

    task automatic model_reserve(input int cnt);
        bit     contig;
        int     need;
        int     take;
        int     first;
        int     steps;
        int     idx;
        int     n;
        t_grant g;
        contig = 1'b1;
        n = 0;
        if (cnt > GRANT_CAP) cnt = GRANT_CAP;
        if (cnt > free_slots) begin
            recycle_len = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (used_map[i] && pub_map[i] && recl_map[i]) begin
                    used_map[i] = 0;
                    recl_map[i] = 0;
                    free_slots++;
                    recycle[recycle_len] = 8'(i);
                    recycle_len++;
                end
            end
            contig = (cnt > 1) ? 1'b0 : 1'b1;
        end
        need = (cnt < free_slots) ? cnt : free_slots;
        if (need > 0) begin
            take  = (need < recycle_len) ? need : recycle_len;
            first = recycle_len - take;
            for (int i = first; i < recycle_len; i++) begin
                idx = int'(recycle[i]);
                if (!used_map[idx]) begin
                    used_map[idx] = 1; pub_map[idx] = 0; recl_map[idx] = 0;
                    free_slots--;
                    grant_q = {grant_q, make_grant(idx, contig)};
                    n++;
                    need--;
                end
            end
            recycle_len = first;
            steps = 0;
            while (need > 0 && steps < NSLOT) begin
                if (!used_map[scan_pos]) begin
                    used_map[scan_pos] = 1; pub_map[scan_pos] = 0; recl_map[scan_pos] = 0;
                    free_slots--;
                    grant_q = {grant_q, make_grant(scan_pos, contig)};
                    n++;
                    need--;
                end
                scan_pos = (scan_pos + 1) % NSLOT;
                steps++;
            end
        end
        if (n == 0) begin
            g = '0;
            g.contig = contig;
            g.last = 1'b1;
            grant_q = {grant_q, g};
        end else begin
            grant_q[grant_q.size() - 1].last = 1'b1;
        end
    endtask

    task automatic model_apply(input logic [1:0] mode, input int cnt, input int slot);
        case (mode)
            MODE_FREE: begin
                if (used_map[slot]) begin
                    used_map[slot] = 0;
                    free_slots++;
                end
            end
            MODE_PUBLISH: begin
                if (used_map[slot]) pub_map[slot] = 1;
            end
            MODE_MARK: begin
                recl_map[slot] = 1;
            end
            default: begin
                model_reserve(cnt);
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // start stays high on return; the caller either sends again or calls hold_start
    task automatic send_item(input logic [1:0] mode, input int cnt, input int slot);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_mode          <= mode;
        i_request_count <= 7'(cnt);
        i_slot_index    <= 8'(slot);
        do @(posedge i_clk); while (busy);
        model_apply(mode, cnt, slot);
    endtask

    task automatic hold_start();
        start <= 1'b0;
    endtask

    task automatic drain_results();
        hold_start();
        while (grant_q.size() > 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_block_number(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        block_idx = value;
        i_cfg_we  <= 1'b0;
    endtask

    function automatic int pick_used_slot();
        int s;
        for (int k = 0; k < 16; k++) begin
            s = $urandom_range(0, NSLOT - 1);
            if (used_map[s]) return s;
        end
        return $urandom_range(0, NSLOT - 1);
    endfunction

    task automatic run_reset();
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (used_map[i]) begin
            used_map[i] = 0; pub_map[i] = 0; recl_map[i] = 0; recycle[i] = 8'd0;
        end
        recycle_len = 0;
        free_slots  = NSLOT;
        scan_pos    = 0;
        block_idx   = 8'd0;
        @(posedge i_clk);
    endtask

    task automatic run_directed_items();
        send_item(MODE_RESERVE, 0, 0);
        send_item(MODE_FREE, 0, 9);
        send_item(MODE_PUBLISH, 0, 9);
        send_item(MODE_MARK, 0, 255);
        send_item(MODE_RESERVE, 1, 0);
        send_item(MODE_RESERVE, 127, 0);
        send_item(MODE_RESERVE, 64, 0);
        send_item(MODE_RESERVE, 100, 0);
        send_item(MODE_RESERVE, 64, 0);
        for (int s = 0; s < 6; s++) begin
            send_item(MODE_PUBLISH, 0, s * 40);
            send_item(MODE_MARK, 0, s * 40);
        end
        send_item(MODE_RESERVE, 3, 0);
        send_item(MODE_RESERVE, 2, 0);
        send_item(MODE_FREE, 0, 0);
        send_item(MODE_FREE, 0, 255);
        send_item(MODE_RESERVE, 1, 0);
        drain_results();
    endtask

    task automatic run_random_items(input int count);
        int r;
        int cnt;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, 12);
                send_item(MODE_RESERVE, cnt, $urandom_range(0, 255));
            end else if (r < 55) begin
                send_item(MODE_FREE, $urandom_range(0, 127),
                          (r < 50) ? pick_used_slot() : $urandom_range(0, 255));
            end else if (r < 75) begin
                send_item(MODE_PUBLISH, $urandom_range(0, 127),
                          (r < 72) ? pick_used_slot() : $urandom_range(0, 255));
            end else begin
                send_item(MODE_MARK, $urandom_range(0, 127),
                          (r < 95) ? pick_used_slot() : $urandom_range(0, 255));
            end
        end
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            got = {o_row_position, o_granted, o_contiguous, o_last};
            if (grant_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result row=%0d", o_row_position));
            end else begin
                want = grant_q.pop_front();
                if (got.row !== want.row)
                    report_mismatch($sformatf("row_position %0d, want %0d", got.row, want.row));
                if (got.granted !== want.granted)
                    report_mismatch($sformatf("granted %b, want %b", got.granted, want.granted));
                if (got.contig !== want.contig)
                    report_mismatch($sformatf("contiguous %b, want %b", got.contig, want.contig));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        run_reset();
        run_directed_items();
        run_random_items(90);
        write_block_number(8'd255);
        run_random_items(70);
        write_block_number(8'($urandom_range(1, 254)));
        run_random_items(70);
        write_block_number(8'd0);
        run_random_items(60);
        write_block_number(8'd128);
        run_random_items(20);
        if (grant_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", grant_q.size()));
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
